/* hdl/csrc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csrc_pkg: shared types and constants of the context symbol rewrite cascade
// Item layout on the cell links, rule storage type, table field codes and the
// context match function used by every rule cell.
// ----------------------------------------------------------------------------
package csrc_pkg;

  // sizes
  localparam int RULES    = 8;
  localparam int SET_SIZE = 8;
  localparam int SYM_W    = 21;
  localparam int RIDX_W   = 3;
  localparam int FIELD_W  = 3;
  localparam int EIDX_W   = 3;
  localparam int ACT_W    = 4;
  localparam int CNT_W    = $clog2(SET_SIZE + 1);
  localparam int CIDX_W   = (RULES > 1) ? $clog2(RULES) : 1;

  // word boundary marker '#'
  localparam logic [SYM_W-1:0] BOUNDARY = 21'd35;

  // table field codes of a write item
  localparam logic [FIELD_W-1:0] FLD_FROM      = 3'd0;
  localparam logic [FIELD_W-1:0] FLD_TO        = 3'd1;
  localparam logic [FIELD_W-1:0] FLD_FRONT_CNT = 3'd2;
  localparam logic [FIELD_W-1:0] FLD_END_CNT   = 3'd3;
  localparam logic [FIELD_W-1:0] FLD_FRONT_ENT = 3'd4;
  localparam logic [FIELD_W-1:0] FLD_END_ENT   = 3'd5;

  typedef logic [SET_SIZE-1:0][SYM_W-1:0] set_t;

  // one item on a link; symbol carries the table value of a write
  typedef struct packed {
    logic               is_write;
    logic [SYM_W-1:0]   symbol;
    logic               last;
    logic [RIDX_W-1:0]  rule_index;
    logic [FIELD_W-1:0] table_field;
    logic [EIDX_W-1:0]  entry_index;
  } item_t;

  // one rewrite rule
  typedef struct packed {
    logic [SYM_W-1:0] from_sym;
    logic [SYM_W-1:0] to_sym;
    logic [CNT_W-1:0] front_cnt;
    logic [CNT_W-1:0] end_cnt;
    set_t             front_set;
    set_t             end_set;
  } rule_t;

  // set membership, parallel compares; an empty set always hits
  function automatic logic set_hit(set_t s, logic [CNT_W-1:0] cnt, logic [SYM_W-1:0] v);
    logic hit;
    hit = (cnt == '0);
    for (int i = 0; i < SET_SIZE; i++) begin
      if ((CNT_W'(i) < cnt) && (s[i] == v)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // rewrite decision for one symbol given its neighbors
  function automatic logic [SYM_W-1:0] rule_decide(rule_t r, logic [SYM_W-1:0] cur,
                                                   logic has_prev, logic [SYM_W-1:0] prev,
                                                   logic has_next, logic [SYM_W-1:0] nxt);
    logic [SYM_W-1:0] pv;
    logic [SYM_W-1:0] nv;
    logic             front_ok;
    logic             end_ok;
    pv       = has_prev ? prev : BOUNDARY;
    nv       = has_next ? nxt : BOUNDARY;
    front_ok = set_hit(r.front_set, r.front_cnt, pv);
    end_ok   = set_hit(r.end_set, r.end_cnt, nv);
    return ((cur == r.from_sym) && front_ok && end_ok) ? r.to_sym : cur;
  endfunction

endpackage
`default_nettype wire

/* hdl/csrc_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csrc_in_if: request channel of the rewrite cascade
// Word symbols and rule table writes, valid/ready handshake.
// ----------------------------------------------------------------------------
interface csrc_in_if;
  import csrc_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [SYM_W-1:0]   symbol;
  logic               word_end;
  logic [RIDX_W-1:0]  rule_index;
  logic [FIELD_W-1:0] table_field;
  logic [EIDX_W-1:0]  entry_index;
  logic [SYM_W-1:0]   table_value;

  modport source (
    output valid, req_type, symbol, word_end, rule_index, table_field,
           entry_index, table_value,
    input  ready
  );

  modport sink (
    input  valid, req_type, symbol, word_end, rule_index, table_field,
           entry_index, table_value,
    output ready
  );
endinterface
`default_nettype wire

/* hdl/csrc_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csrc_out_if: result channel of the rewrite cascade
// Rewritten symbols with an end-of-word flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface csrc_out_if;
  import csrc_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol_out;
  logic             last;

  modport source (
    output valid, symbol_out, last,
    input  ready
  );

  modport sink (
    input  valid, symbol_out, last,
    output ready
  );
endinterface
`default_nettype wire

/* hdl/csrc_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csrc_cell: one rule of the rewrite cascade
// Holds its rule, the previous and the pending symbol of the current word, and
// an output register toward the next cell. A symbol is decided once its right
// neighbor arrives; an end-of-word symbol gets a separate flush step for the boundary
// decision. A disabled cell passes items through. Write items update the rule
// whose slot matches and travel on.
// ----------------------------------------------------------------------------
module csrc_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [csrc_pkg::CIDX_W-1:0] cell_index,
  input  logic                     enable,
  input  logic                     clear,
  input  logic                     in_valid,
  input  csrc_pkg::item_t          in_item,
  output logic                     in_ready,
  output logic                     out_valid,
  output csrc_pkg::item_t          out_item,
  input  logic                     out_ready
);
  import csrc_pkg::*;

  rule_t            rule;
  rule_t            rule_next;
  logic [SYM_W-1:0] prev_sym;
  logic [SYM_W-1:0] prev_sym_next;
  logic             prev_valid;
  logic             prev_valid_next;
  logic [SYM_W-1:0] pend_sym;
  logic [SYM_W-1:0] pend_sym_next;
  logic             pend_valid;
  logic             pend_valid_next;
  logic             flush;
  logic             flush_next;

  logic             can_load;
  logic             take;
  logic             emit;
  item_t            emit_item;
  logic             wr;
  logic [SYM_W-1:0] dec_sym;

  // handshake and the single decision of this cycle
  always_comb begin
    can_load = !out_valid || out_ready;
    in_ready = can_load && !(enable && flush);
    take     = in_valid && in_ready;
    dec_sym  = rule_decide(rule, pend_valid ? pend_sym : in_item.symbol,
                           pend_valid && prev_valid, prev_sym,
                           pend_valid && !flush, in_item.symbol);
  end

  // stage control
  always_comb begin
    emit            = 1'b0;
    emit_item       = in_item;
    wr              = 1'b0;
    prev_sym_next   = prev_sym;
    prev_valid_next = prev_valid;
    pend_sym_next   = pend_sym;
    pend_valid_next = pend_valid;
    flush_next      = flush;
    if (enable && flush) begin
      // boundary decision on the word's final symbol
      if (can_load) begin
        emit               = 1'b1;
        emit_item.is_write = 1'b0;
        emit_item.symbol   = dec_sym;
        emit_item.last     = 1'b1;
        prev_valid_next    = 1'b0;
        pend_valid_next    = 1'b0;
        flush_next         = 1'b0;
      end
    end else if (take) begin
      if (in_item.is_write) begin
        wr   = 1'b1;
        emit = 1'b1;
      end else if (!enable) begin
        emit = 1'b1;
      end else if (pend_valid) begin
        emit             = 1'b1;
        emit_item.symbol = dec_sym;
        emit_item.last   = 1'b0;
        prev_sym_next    = pend_sym;
        prev_valid_next  = 1'b1;
        pend_sym_next    = in_item.symbol;
        flush_next       = in_item.last;
      end else if (in_item.last) begin
        // one-symbol word: both sides are boundaries
        emit             = 1'b1;
        emit_item.symbol = dec_sym;
        emit_item.last   = 1'b1;
      end else begin
        pend_sym_next   = in_item.symbol;
        pend_valid_next = 1'b1;
      end
    end
    if (clear) begin
      prev_valid_next = 1'b0;
      pend_valid_next = 1'b0;
      flush_next      = 1'b0;
    end
  end

  // rule table write
  always_comb begin
    rule_next = rule;
    if (wr && (32'(in_item.rule_index) == 32'(cell_index))) begin
      unique case (in_item.table_field)
        FLD_FROM:      rule_next.from_sym = in_item.symbol;
        FLD_TO:        rule_next.to_sym   = in_item.symbol;
        FLD_FRONT_CNT: begin
          rule_next.front_cnt = (in_item.symbol > SYM_W'(SET_SIZE)) ?
                                CNT_W'(SET_SIZE) : CNT_W'(in_item.symbol);
        end
        FLD_END_CNT:   begin
          rule_next.end_cnt = (in_item.symbol > SYM_W'(SET_SIZE)) ?
                              CNT_W'(SET_SIZE) : CNT_W'(in_item.symbol);
        end
        FLD_FRONT_ENT: begin
          for (int i = 0; i < SET_SIZE; i++) begin
            if (32'(in_item.entry_index) == i) begin
              rule_next.front_set[i] = in_item.symbol;
            end
          end
        end
        FLD_END_ENT:   begin
          for (int i = 0; i < SET_SIZE; i++) begin
            if (32'(in_item.entry_index) == i) begin
              rule_next.end_set[i] = in_item.symbol;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // control and rule registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rule       <= '0;
      prev_valid <= 1'b0;
      pend_valid <= 1'b0;
      flush      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rule       <= rule_next;
      prev_valid <= prev_valid_next;
      pend_valid <= pend_valid_next;
      flush      <= flush_next;
      if (can_load) begin
        out_valid <= emit;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prev_sym <= prev_sym_next;
    pend_sym <= pend_sym_next;
    if (can_load && emit) begin
      out_item <= emit_item;
    end
  end

  // checks
  a_flush_pend : assert property (@(posedge clk) disable iff (rst)
    flush |-> pend_valid)
    else $error("flush without a pending symbol");

  a_prev_pend : assert property (@(posedge clk) disable iff (rst)
    prev_valid |-> pend_valid)
    else $error("previous symbol held without a pending one");

  a_bypass_empty : assert property (@(posedge clk) disable iff (rst)
    !enable |-> !pend_valid && !flush)
    else $error("disabled cell holds word state");

  a_last_symbol : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.last |-> !out_item.is_write)
    else $error("end-of-word flag on a write item");

endmodule
`default_nettype wire

/* hdl/context_symbol_rewrite_cascade_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// context_symbol_rewrite_cascade_top: rule cascade for symbol streams
// A row of RULES rule cells; each rewrites a symbol from its left and right
// neighbors and hands items to the next cell every cycle unless a stall holds them.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        req_type symbol word_end rule_index
//                                    table_field entry_index table_value
//   res      out  valid/ready        symbol_out last
//   cfg      in   cfg_we             cfg_wdata (active_rules)
//
// One item per cycle enters and leaves while no cell flushes and res is ready;
// each cell is one register stage, and a symbol also waits in it for a neighbor.
// An end-of-word symbol takes an extra flush step in each active cell for the
// boundary decision. Write items take no result slot and are dropped at the
// end of the row. Synchronous reset clears rules, word state and valids;
// a stall on res backs up cell by cell to req.ready.
// ----------------------------------------------------------------------------
module context_symbol_rewrite_cascade_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [csrc_pkg::ACT_W-1:0] cfg_wdata,
  csrc_in_if.sink                   req,
  csrc_out_if.source                res
);
  import csrc_pkg::*;

  logic [ACT_W-1:0] active_rules;
  logic [RULES:0]   link_valid;
  logic [RULES:0]   link_ready;
  item_t [RULES:0]  link_item;
  logic [RULES-1:0] cell_en;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_rules <= '0;
    end else if (cfg_we) begin
      active_rules <= cfg_wdata;
    end
  end

  // request into the row; a write item never carries the end-of-word flag
  assign link_valid[0]            = req.valid;
  assign link_item[0].is_write    = req.req_type;
  assign link_item[0].symbol      = req.req_type ? req.table_value : req.symbol;
  assign link_item[0].last        = req.word_end && !req.req_type;
  assign link_item[0].rule_index  = req.rule_index;
  assign link_item[0].table_field = req.table_field;
  assign link_item[0].entry_index = req.entry_index;
  assign req.ready                = link_ready[0];

  // row of rule cells
  for (genvar k = 0; k < RULES; k++) begin : g_cell
    assign cell_en[k] = (32'(active_rules) > k);

    csrc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (CIDX_W'(k)),
      .enable     (cell_en[k]),
      .clear      (cfg_we),
      .in_valid   (link_valid[k]),
      .in_item    (link_item[k]),
      .in_ready   (link_ready[k]),
      .out_valid  (link_valid[k+1]),
      .out_item   (link_item[k+1]),
      .out_ready  (link_ready[k+1])
    );
  end

  // results out; write items are consumed here
  assign res.valid         = link_valid[RULES] && !link_item[RULES].is_write;
  assign res.symbol_out    = link_item[RULES].symbol;
  assign res.last          = link_item[RULES].last;
  assign link_ready[RULES] = res.ready || link_item[RULES].is_write;

endmodule
`default_nettype wire

/* tb/tb_context_symbol_rewrite_cascade_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_context_symbol_rewrite_cascade_top: self-checking bench for the cascade
// Streams words and rule table writes into the block with random gaps on
// both channels. A scoreboard class keeps its own rule tables and per-rule
// neighbor state and predicts every rewritten symbol. Each result that
// leaves is compared in order, over several active rule counts.
// ----------------------------------------------------------------------------
module tb_context_symbol_rewrite_cascade_top;
  import csrc_pkg::*;

  localparam logic REQ_SYMBOL = 1'b0;
  localparam logic REQ_WRITE  = 1'b1;

  // field codes the block ignores
  localparam logic [FIELD_W-1:0] FLD_SPARE_LO = 3'd6;
  localparam logic [FIELD_W-1:0] FLD_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS  = 120;
  localparam int SETTLE_CYCLES = 6 * RULES;
  localparam int LONG_STALL    = 80;
  localparam int CYCLE_LIMIT   = 200000;

  localparam logic [SYM_W-1:0] SYM_ALL_ONES = '1;
  localparam logic [SYM_W-1:0] SYM_TOP_CODE = 21'h10FFFF;
  localparam logic [SYM_W-1:0] LETTER_A     = 21'd97;

  typedef struct packed {
    logic               req_type;
    logic [SYM_W-1:0]   symbol;
    logic               word_end;
    logic [RIDX_W-1:0]  rule_index;
    logic [FIELD_W-1:0] table_field;
    logic [EIDX_W-1:0]  entry_index;
    logic [SYM_W-1:0]   table_value;
  } req_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol_out;
    logic             last;
  } word_result_t;

  // Rule tables, per-rule held symbols and the queue of expected results
  class cascade_scoreboard;
    logic [SYM_W-1:0] from_sym [RULES];
    logic [SYM_W-1:0] to_sym [RULES];
    logic [SYM_W-1:0] front_set [RULES][SET_SIZE];
    logic [SYM_W-1:0] end_set [RULES][SET_SIZE];
    int unsigned      front_cnt [RULES];
    int unsigned      end_cnt [RULES];
    logic [SYM_W-1:0] prev_sym [RULES];
    logic [SYM_W-1:0] held_sym [RULES];
    bit               prev_ok [RULES];
    bit               held_ok [RULES];
    int unsigned      rule_count;
    word_result_t     expected_symbols[$];
    int errors = 0;
    int results_checked = 0;
    int rewrites = 0;
    int words_done = 0;
    int writes_applied = 0;

    function void clear_stage(int k);
      prev_sym[k] = '0;
      held_sym[k] = '0;
      prev_ok[k]  = 1'b0;
      held_ok[k]  = 1'b0;
    endfunction

    function void reset_all();
      for (int k = 0; k < RULES; k++) begin
        from_sym[k]  = '0;
        to_sym[k]    = '0;
        front_cnt[k] = 0;
        end_cnt[k]   = 0;
        for (int j = 0; j < SET_SIZE; j++) begin
          front_set[k][j] = '0;
          end_set[k][j]   = '0;
        end
        clear_stage(k);
      end
      rule_count = 0;
      expected_symbols.delete();
    endfunction

    // a new rule count also drops every held symbol
    function void set_rule_count(logic [ACT_W-1:0] v);
      rule_count = 32'(v);
      for (int k = 0; k < RULES; k++) clear_stage(k);
    endfunction

    function bit in_context(bit front_side, int k, logic [SYM_W-1:0] v);
      int unsigned cnt;
      cnt = front_side ? front_cnt[k] : end_cnt[k];
      if (cnt == 0) return 1'b1;
      for (int i = 0; i < cnt && i < SET_SIZE; i++) begin
        if ((front_side ? front_set[k][i] : end_set[k][i]) == v) return 1'b1;
      end
      return 1'b0;
    endfunction

    // missing neighbors read as the boundary marker
    function logic [SYM_W-1:0] rewrite_symbol(int k, logic [SYM_W-1:0] cur,
                                              bit has_prev, logic [SYM_W-1:0] prev,
                                              bit has_next, logic [SYM_W-1:0] nxt);
      bit front_ok;
      bit end_ok;
      if (cur != from_sym[k]) return cur;
      front_ok = in_context(1'b1, k, has_prev ? prev : BOUNDARY);
      end_ok   = in_context(1'b0, k, has_next ? nxt : BOUNDARY);
      if (!(front_ok && end_ok)) return cur;
      if (to_sym[k] != cur) rewrites++;
      return to_sym[k];
    endfunction

    function void apply_write(req_item_t it);
      int unsigned      r;
      logic [SYM_W-1:0] v;
      r = 32'(it.rule_index);
      v = it.table_value;
      if (r >= RULES) return;
      if (it.table_field <= FLD_END_ENT) writes_applied++;
      case (it.table_field)
        FLD_FROM:      from_sym[r] = v;
        FLD_TO:        to_sym[r] = v;
        FLD_FRONT_CNT: front_cnt[r] = (v > SET_SIZE) ? SET_SIZE : 32'(v);
        FLD_END_CNT:   end_cnt[r] = (v > SET_SIZE) ? SET_SIZE : 32'(v);
        FLD_FRONT_ENT: if (it.entry_index < SET_SIZE) front_set[r][it.entry_index] = v;
        FLD_END_ENT:   if (it.entry_index < SET_SIZE) end_set[r][it.entry_index] = v;
        default: ;
      endcase
    endfunction

    // push the symbol through each active rule; a word end flushes every active rule
    function void note_input(req_item_t it);
      int unsigned      stages;
      logic [SYM_W-1:0] flow[$];
      logic [SYM_W-1:0] nxt[$];
      word_result_t     res_item;
      if (it.req_type == REQ_WRITE) begin
        apply_write(it);
        return;
      end
      stages = (rule_count > RULES) ? RULES : rule_count;
      flow = {flow, it.symbol};
      for (int k = 0; k < stages; k++) begin
        nxt.delete();
        foreach (flow[i]) begin
          if (held_ok[k]) begin
            nxt = {nxt, rewrite_symbol(k, held_sym[k], prev_ok[k], prev_sym[k],
                                       1'b1, flow[i])};
            prev_sym[k] = held_sym[k];
            prev_ok[k]  = 1'b1;
          end
          held_sym[k] = flow[i];
          held_ok[k]  = 1'b1;
        end
        if (it.word_end) begin
          if (held_ok[k]) begin
            nxt = {nxt, rewrite_symbol(k, held_sym[k], prev_ok[k], prev_sym[k],
                                       1'b0, '0)};
          end
          clear_stage(k);
        end
        flow = nxt;
      end
      foreach (flow[i]) begin
        res_item.symbol_out = flow[i];
        res_item.last       = it.word_end && (i == flow.size() - 1);
        expected_symbols    = {expected_symbols, res_item};
      end
      if (it.word_end) words_done++;
    endfunction

    function void check_result(logic [SYM_W-1:0] s, logic l);
      word_result_t want;
      results_checked++;
      if (expected_symbols.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual symbol_out=%h last=%b",
                 $time, s, l);
        return;
      end
      want = expected_symbols.pop_front();
      if (s !== want.symbol_out) begin
        errors++;
        $display("%0t symbol_out mismatch: expected %h, actual %h",
                 $time, want.symbol_out, s);
      end
      if (l !== want.last) begin
        errors++;
        $display("%0t last mismatch on symbol %h: expected %b, actual %b",
                 $time, want.symbol_out, want.last, l);
      end
    endfunction
  endclass

  cascade_scoreboard rewrite_sb;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [ACT_W-1:0] cfg_wdata;
  bit               gaps_on = 1'b1;
  bit               long_stall_req = 1'b0;
  int               stall_left = 0;
  int               items_sent = 0;
  int               cycle_count = 0;
  int               settings_run = 0;

  csrc_in_if  req_ch();
  csrc_out_if res_ch();

  context_symbol_rewrite_cascade_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t run stopped at the cycle limit", $time);
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: check accepted items, random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) rewrite_sb.check_result(res_ch.symbol_out, res_ch.last);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left     = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= !(gaps_on && $urandom_range(99) < 13);
      end
    end
  end

  // mostly letters a..d and the boundary marker, now and then any 21-bit value
  function automatic logic [SYM_W-1:0] pick_symbol();
    int r;
    r = $urandom_range(99);
    if (r < 12) return BOUNDARY;
    if (r < 92) return LETTER_A + SYM_W'($urandom_range(3));
    if (r < 97) return SYM_W'($urandom_range(SYM_TOP_CODE));
    return SYM_W'($urandom);
  endfunction

  task automatic send_item(input req_item_t it);
    while (gaps_on && $urandom_range(99) < 13) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= it.req_type;
    req_ch.symbol      <= it.symbol;
    req_ch.word_end    <= it.word_end;
    req_ch.rule_index  <= it.rule_index;
    req_ch.table_field <= it.table_field;
    req_ch.entry_index <= it.entry_index;
    req_ch.table_value <= it.table_value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    rewrite_sb.note_input(it);
  endtask

  // table fields carry noise on a symbol item
  task automatic send_symbol(input logic [SYM_W-1:0] s, input logic last_of_word);
    req_item_t it;
    it.req_type    = REQ_SYMBOL;
    it.symbol      = s;
    it.word_end    = last_of_word;
    it.rule_index  = RIDX_W'($urandom);
    it.table_field = FIELD_W'($urandom);
    it.entry_index = EIDX_W'($urandom);
    it.table_value = SYM_W'($urandom);
    send_item(it);
    items_sent++;
  endtask

  task automatic send_write(input logic [RIDX_W-1:0] r, input logic [FIELD_W-1:0] f,
                            input logic [EIDX_W-1:0] e, input logic [SYM_W-1:0] v);
    req_item_t it;
    it.req_type    = REQ_WRITE;
    it.symbol      = SYM_W'($urandom);
    it.word_end    = 1'($urandom_range(1));
    it.rule_index  = r;
    it.table_field = f;
    it.entry_index = e;
    it.table_value = v;
    send_item(it);
    if (f <= FLD_END_ENT) items_sent++;
  endtask

  task automatic load_random_rule(input logic [RIDX_W-1:0] k);
    int nf;
    int ne;
    nf = $urandom_range(3);
    ne = $urandom_range(3);
    send_write(k, FLD_FROM, EIDX_W'($urandom), pick_symbol());
    send_write(k, FLD_TO, EIDX_W'($urandom), pick_symbol());
    // now and then an oversized count that saturates over stale entries
    send_write(k, FLD_FRONT_CNT, EIDX_W'($urandom),
               ($urandom_range(7) == 0) ? SYM_W'($urandom) : SYM_W'(nf));
    send_write(k, FLD_END_CNT, EIDX_W'($urandom),
               ($urandom_range(7) == 0) ? SYM_W'($urandom) : SYM_W'(ne));
    for (int i = 0; i < nf; i++) send_write(k, FLD_FRONT_ENT, EIDX_W'(i), pick_symbol());
    for (int i = 0; i < ne; i++) send_write(k, FLD_END_ENT, EIDX_W'(i), pick_symbol());
  endtask

  // a word, with a table write slipped in now and then while symbols are in flight
  task automatic send_random_word(input int len, input logic finish);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) begin
        send_write(RIDX_W'($urandom), FIELD_W'($urandom_range(FLD_END_ENT)),
                   EIDX_W'($urandom), pick_symbol());
      end
      send_symbol(pick_symbol(), finish && (i == len - 1));
    end
  endtask

  // wait until every result is back and the row has emptied
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (rewrite_sb.expected_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rule_count(input logic [ACT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    rewrite_sb.set_rule_count(v);
    settings_run++;
  endtask

  // main sequence
  initial begin
    logic [ACT_W-1:0] rule_plan [8];
    int p;
    rule_plan = '{4'd3, 4'd8, 4'd15, 4'd1, 4'd0, 4'd2, 4'd6, 4'd4};
    rewrite_sb = new();
    rewrite_sb.reset_all();
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_SYMBOL;
    req_ch.symbol      = '0;
    req_ch.word_end    = 1'b0;
    req_ch.rule_index  = '0;
    req_ch.table_field = FLD_FROM;
    req_ch.entry_index = '0;
    req_ch.table_value = '0;
    res_ch.ready       = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no rules: symbols pass through, field extremes, one-symbol word
    write_rule_count(4'd0);
    send_symbol('0, 1'b0);
    send_symbol(SYM_ALL_ONES, 1'b0);
    send_symbol(SYM_TOP_CODE, 1'b0);
    send_symbol(BOUNDARY, 1'b1);
    send_symbol(LETTER_A, 1'b1);

    // every table field, a saturating count, the last set slot, spare fields
    send_write(3'd0, FLD_FROM, 3'd0, LETTER_A);
    send_write(3'd0, FLD_TO, 3'd0, LETTER_A + 21'd1);
    send_write(3'd0, FLD_FRONT_CNT, 3'd0, SYM_ALL_ONES);
    send_write(3'd0, FLD_FRONT_ENT, 3'd0, BOUNDARY);
    send_write(3'd0, FLD_FRONT_ENT, 3'd7, LETTER_A + 21'd2);
    send_write(3'd7, FLD_FROM, 3'd0, LETTER_A + 21'd1);
    send_write(3'd7, FLD_TO, 3'd0, SYM_ALL_ONES);
    send_write(3'd7, FLD_END_CNT, 3'd0, 21'd1);
    send_write(3'd7, FLD_END_ENT, 3'd0, BOUNDARY);
    send_write(3'd1, FLD_FROM, 3'd0, BOUNDARY);
    send_write(3'd1, FLD_TO, 3'd0, LETTER_A + 21'd3);
    send_write(3'd3, FLD_SPARE_LO, 3'd5, SYM_ALL_ONES);
    send_write(3'd3, FLD_SPARE_HI, 3'd2, SYM_ALL_ONES);
    drain();

    // a rule count above the row size runs the full row
    write_rule_count(4'd15);
    send_symbol(LETTER_A, 1'b0);
    send_symbol(LETTER_A + 21'd2, 1'b0);
    send_symbol(BOUNDARY, 1'b0);
    send_symbol(LETTER_A, 1'b0);
    send_symbol(LETTER_A + 21'd1, 1'b1);

    // random phases, each under its own rule count
    items_sent = 0;
    p = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain();
      write_rule_count(rule_plan[p % 8]);
      gaps_on = (p != 2);
      repeat ($urandom_range(2, 1)) load_random_rule(RIDX_W'($urandom_range(RULES - 1)));
      if ($urandom_range(3) == 0) begin
        send_write(RIDX_W'($urandom), $urandom_range(1) ? FLD_SPARE_HI : FLD_SPARE_LO,
                   EIDX_W'($urandom), SYM_W'($urandom));
      end
      if (p == 1) begin
        // hold results back so the row fills and req stalls
        long_stall_req = 1'b1;
        send_random_word(24, 1'b1);
      end
      repeat ($urandom_range(5, 3)) send_random_word($urandom_range(6, 1), 1'b1);
      // leave a word open; the next rule count write drops what is held
      if (p == 0) send_random_word(3, 1'b0);
      p++;
    end
    drain();

    if (rewrite_sb.expected_symbols.size() != 0) begin
      rewrite_sb.errors++;
      $display("%0t missing results: expected %0d more, oldest %h, actual none",
               $time, rewrite_sb.expected_symbols.size(),
               rewrite_sb.expected_symbols[0].symbol_out);
    end
    $display("Ran %0d rule count settings, %0d finished words, %0d table writes.",
             settings_run, rewrite_sb.words_done, rewrite_sb.writes_applied);
    $display("Compared %0d output symbols; %0d rule applications changed a symbol.",
             rewrite_sb.results_checked, rewrite_sb.rewrites);
    if (rewrite_sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
